[rtl/rfs_pkg.sv]
// Shared types, constants and request codes for the replay sample store.
package rfs_pkg;

    localparam int DEPTH       = 16;               // entries, power of two
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int DATA_WIDTH  = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int FILL_W      = 5;

    localparam logic [FILL_W-1:0]      CAP_RESET = FILL_W'(16);
    localparam logic [FILL_W-1:0]      CAP_MAX   = FILL_W'(DEPTH);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_REMOVE  = 3'd1;
    localparam logic [2:0] REQ_SAMPLE  = 3'd2;
    localparam logic [2:0] REQ_UPDATE  = 3'd3;
    localparam logic [2:0] REQ_ADVANCE = 3'd4;
    localparam logic [2:0] REQ_CLEAR   = 3'd5;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX  = 2'd1;
    localparam logic [1:0] STATUS_ZERO_BATCH = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  entry_index;
        logic [7:0]  batch_count;
        logic [31:0] payload_in;
        logic [15:0] age_in;
        logic [15:0] usage_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  index_out;
        logic [31:0] payload_out;
        logic [15:0] age_out;
        logic [15:0] usage_out;
        logic        valid_entry;
        logic        last;
        logic [4:0]  fill_count;
    } result_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]  payload;
        logic [COUNT_WIDTH-1:0] age;
        logic [COUNT_WIDTH-1:0] usage;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

endpackage

[rtl/fifo_replay_sample_store.sv]
// Top level of the replay sample store: capacity register and block wiring.
//
// Requests enter on req, taken at a rising edge with start high and busy low.
// Results leave on result, each valid for the single cycle that strobe marks;
// the receiver cannot hold them off. Every request ends with a result whose
// last bit is set; a sample request gives one result per emitted entry.
// Add, update, clear, unknown codes, a sample or advance on an empty store,
// requests with a bad index or zero batch, and a remove of the newest entry
// finish at the accepting edge: busy stays low and the result shows in the
// next cycle, so such items can enter every cycle.
// Otherwise remove, sample and advance walk the entry memory, one entry per
// cycle: busy stays high while the walk moves, emits or ages its entries (at
// most 16), and the next item can enter once busy falls. A sample gives one
// result per entry walked; remove and advance give theirs when the walk ends.
// The capacity register is written through cfg_we and cfg_data; the user
// must write it only while idle, which the block does not enforce. 0 acts as
// 1 and values above the depth act as the depth. Reset empties the store and
// sets the capacity to 16; the entry memory is not cleared.
module fifo_replay_sample_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  rfs_pkg::req_t               req,
    output logic                        busy,
    output logic                        strobe,
    output rfs_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [rfs_pkg::FILL_W-1:0]  cfg_data
);

    logic [rfs_pkg::FILL_W-1:0] cap_reg;
    logic [rfs_pkg::FILL_W-1:0] cap_eff;
    rfs_pkg::mem_wr_t           mem_wr;
    logic [rfs_pkg::IDX_W-1:0]  rd_addr;
    rfs_pkg::entry_t            rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= rfs_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // clamp capacity into 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = rfs_pkg::FILL_W'(1);
        end
        else if (cap_reg > rfs_pkg::CAP_MAX)
        begin
            cap_eff = rfs_pkg::CAP_MAX;
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    rfs_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .cap_eff (cap_eff),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result),
        .mem_wr  (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rfs_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

[rtl/rfs_mem.sv]
// Entry memory: one write port, one read port with registered read data.
module rfs_mem (
    input  logic                                clk,
    input  rfs_pkg::mem_wr_t                    wr,
    input  logic [rfs_pkg::IDX_W-1:0]           rd_addr,
    output rfs_pkg::entry_t                     rd_data
);

    rfs_pkg::entry_t mem [rfs_pkg::DEPTH];
    rfs_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rfs_seq.sv]
// Request sequencer: ring pointers, entry walks and result register.
module rfs_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  rfs_pkg::req_t                req,
    input  logic [rfs_pkg::FILL_W-1:0]   cap_eff,
    output logic                         busy,
    output logic                         strobe,
    output rfs_pkg::result_t             result,
    output rfs_pkg::mem_wr_t             mem_wr,
    output logic [rfs_pkg::IDX_W-1:0]    rd_addr,
    input  rfs_pkg::entry_t              rd_data
);

    localparam int IW = rfs_pkg::IDX_W;
    localparam int FW = rfs_pkg::FILL_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic             state_reg,  state_next;
    logic [IW-1:0]    head_reg,   head_next;
    logic [FW-1:0]    total_reg,  total_next;
    logic [2:0]       op_reg,     op_next;
    logic [IW-1:0]    pos_reg,    pos_next;
    logic [IW-1:0]    end_reg,    end_next;
    logic             strobe_reg, strobe_next;
    rfs_pkg::result_t result_reg, result_next;

    logic             accept;
    logic             idx_ok;
    logic [FW-1:0]    idx_ext;
    logic [FW-1:0]    n_sample;
    logic             over;
    logic [FW-1:0]    evict;
    logic [IW-1:0]    head_add;
    logic [FW-1:0]    total_kept;
    logic             walk_last;
    logic             ack;
    logic [1:0]       ack_status;
    rfs_pkg::entry_t  entry_mod;
    rfs_pkg::entry_t  entry_in;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign strobe  = strobe_reg;
    assign result  = result_reg;

    assign idx_ext = FW'(req.entry_index);
    assign idx_ok  = idx_ext < total_reg;

    // batch below fill fits the fill width
    assign n_sample = ({3'b000, total_reg} > req.batch_count) ? FW'(req.batch_count)
                                                              : total_reg;

    // evict from the front so one slot below capacity remains
    assign over       = total_reg >= cap_eff;
    assign evict      = total_reg - cap_eff + FW'(1);
    assign head_add   = over ? head_reg + evict[IW-1:0] : head_reg;
    assign total_kept = over ? cap_eff - FW'(1) : total_reg;

    assign walk_last = (pos_reg == end_reg);

    assign entry_in.payload = req.payload_in[rfs_pkg::DATA_WIDTH-1:0];
    assign entry_in.age     = req.age_in[rfs_pkg::COUNT_WIDTH-1:0];
    assign entry_in.usage   = req.usage_in[rfs_pkg::COUNT_WIDTH-1:0];

    always_comb
    begin
        entry_mod = rd_data;
        case (op_reg)
            rfs_pkg::REQ_SAMPLE:
            begin
                if (rd_data.usage != rfs_pkg::COUNT_MAX)
                begin
                    entry_mod.usage = rd_data.usage + rfs_pkg::COUNT_WIDTH'(1);
                end
            end
            rfs_pkg::REQ_ADVANCE:
            begin
                if (rd_data.age != rfs_pkg::COUNT_MAX)
                begin
                    entry_mod.age = rd_data.age + rfs_pkg::COUNT_WIDTH'(1);
                end
            end
            default:
            begin
                entry_mod = rd_data;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        total_next  = total_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        mem_wr      = '0;
        rd_addr     = head_reg + pos_reg + IW'(1);
        ack         = 1'b0;
        ack_status  = rfs_pkg::STATUS_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next = req.req_type;
                    case (req.req_type)
                        rfs_pkg::REQ_ADD:
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = head_add + total_kept[IW-1:0];
                            mem_wr.data = entry_in;
                            head_next   = head_add;
                            total_next  = total_kept + FW'(1);
                            ack         = 1'b1;
                        end
                        rfs_pkg::REQ_REMOVE:
                        begin
                            if (!idx_ok)
                            begin
                                ack        = 1'b1;
                                ack_status = rfs_pkg::STATUS_BAD_INDEX;
                            end
                            else if (idx_ext + FW'(1) == total_reg)
                            begin
                                total_next = total_reg - FW'(1);
                                ack        = 1'b1;
                            end
                            else
                            begin
                                // shift later entries down one by one
                                pos_next   = IW'(idx_ext + FW'(1));
                                end_next   = IW'(total_reg - FW'(1));
                                rd_addr    = head_reg + IW'(idx_ext + FW'(1));
                                state_next = ST_WALK;
                            end
                        end
                        rfs_pkg::REQ_SAMPLE:
                        begin
                            if (req.batch_count == 8'd0)
                            begin
                                ack        = 1'b1;
                                ack_status = rfs_pkg::STATUS_ZERO_BATCH;
                            end
                            else if (total_reg == '0)
                            begin
                                ack = 1'b1;
                            end
                            else
                            begin
                                pos_next   = '0;
                                end_next   = IW'(n_sample - FW'(1));
                                rd_addr    = head_reg;
                                state_next = ST_WALK;
                            end
                        end
                        rfs_pkg::REQ_UPDATE:
                        begin
                            ack = 1'b1;
                            if (!idx_ok)
                            begin
                                ack_status = rfs_pkg::STATUS_BAD_INDEX;
                            end
                            else
                            begin
                                mem_wr.en   = 1'b1;
                                mem_wr.addr = head_reg + IW'(idx_ext);
                                mem_wr.data = entry_in;
                            end
                        end
                        rfs_pkg::REQ_ADVANCE:
                        begin
                            if (total_reg == '0)
                            begin
                                ack = 1'b1;
                            end
                            else
                            begin
                                pos_next   = '0;
                                end_next   = IW'(total_reg - FW'(1));
                                rd_addr    = head_reg;
                                state_next = ST_WALK;
                            end
                        end
                        rfs_pkg::REQ_CLEAR:
                        begin
                            total_next = '0;
                            head_next  = '0;
                            ack        = 1'b1;
                        end
                        default:
                        begin
                            ack = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // write back the entry read in the previous cycle
                mem_wr.en   = 1'b1;
                mem_wr.addr = (op_reg == rfs_pkg::REQ_REMOVE) ? head_reg + pos_reg - IW'(1)
                                                              : head_reg + pos_reg;
                mem_wr.data = entry_mod;
                pos_next    = pos_reg + IW'(1);

                if (op_reg == rfs_pkg::REQ_SAMPLE)
                begin
                    strobe_next             = 1'b1;
                    result_next.status      = rfs_pkg::STATUS_OK;
                    result_next.index_out   = 4'(pos_reg);
                    result_next.payload_out = 32'(entry_mod.payload);
                    result_next.age_out     = 16'(entry_mod.age);
                    result_next.usage_out   = 16'(entry_mod.usage);
                    result_next.valid_entry = 1'b1;
                    result_next.last        = walk_last;
                    result_next.fill_count  = total_reg;
                end

                if (walk_last)
                begin
                    state_next = ST_IDLE;
                    if (op_reg == rfs_pkg::REQ_REMOVE)
                    begin
                        total_next = total_reg - FW'(1);
                    end
                    if (op_reg != rfs_pkg::REQ_SAMPLE)
                    begin
                        ack = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ack)
        begin
            strobe_next            = 1'b1;
            result_next            = '0;
            result_next.status     = ack_status;
            result_next.last       = 1'b1;
            result_next.fill_count = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            total_reg  <= '0;
            op_reg     <= rfs_pkg::REQ_ADD;
            pos_reg    <= '0;
            end_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            total_reg  <= total_next;
            op_reg     <= op_next;
            pos_reg    <= pos_next;
            end_reg    <= end_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule
